// ----- hdl/array_stack_engine_top_defines.svh -----
// Assertion macros for the stack engine.
// ASE_ASSERT_IMP: same-cycle implication. ASE_ASSERT_NXT: next-cycle implication.
// Both are sampled on clk and disabled while arst_n is low.
`ifndef ARRAY_STACK_ENGINE_TOP_DEFINES_SVH
`define ARRAY_STACK_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define ASE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASE_ASSERT_IMP(lbl, ante, cons, msg)
`define ASE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hdl/ase_pkg.sv -----
package ase_pkg;

	localparam int DEPTH_DEF     = 8;
	localparam int WORD_BITS_DEF = 32;

	// stream word layout
	localparam int IN_DATA_BITS  = 40;
	localparam int IN_USER_BITS  = 2;
	localparam int OUT_DATA_BITS = 40;
	localparam int OUT_USER_BITS = 2;
	localparam int VALUE_BITS    = 32;
	localparam int POS_BITS      = 4;
	localparam int COUNT_BITS    = 4;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2,
		OP_PEEP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

endpackage

// ----- hdl/array_stack_engine_top.sv -----
// LIFO stack engine.
// Request channel (s_*): one word per request; s_tuser carries the operation
// (push, pop, peek top, peep at position), s_tdata the push word and position.
// Result channel (m_*): exactly one word per request, in request order, with
// the word read (-1 on push or error), a status code, the empty and full flags
// and the entry count as they stand after the request.
// A request accepted by s_tready passes through stage 1 (decode and RAM read)
// and then the result register before it shows on m_tvalid. Throughput: one
// request per cycle, sustained while m_tready stays high. The entries live in
// a single synchronous RAM; the write for a push lands at the accepting edge,
// so a following pop/peek/peep in the next cycle reads it with no bypass.
// The fill count is kept in a register and updated at the accepting edge.
// Reset (arst_n low, asynchronous) empties the stack and drops any result in
// flight; the RAM contents are not cleared and are never read before written.
// When the receiver stalls, the result register holds, the RAM read stage
// holds behind it, and s_tready drops once both are full.
`include "array_stack_engine_top_defines.svh"

module array_stack_engine_top #(
	parameter int DEPTH     = ase_pkg::DEPTH_DEF,
	parameter int WORD_BITS = ase_pkg::WORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [31:0] push_value, [35:32] position, [39:36] zero
	input  logic [ase_pkg::IN_DATA_BITS-1:0]   s_tdata,
	// [1:0] operation
	input  logic [ase_pkg::IN_USER_BITS-1:0]   s_tuser,
	// result
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [31:0] read_value, [32] is_empty, [33] is_full, [37:34] entry_count,
	// [39:38] zero
	output logic [ase_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	// [1:0] status
	output logic [ase_pkg::OUT_USER_BITS-1:0]  m_tuser
);

	import ase_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > POS_BITS) ? CW : POS_BITS; // compare width

	// ---------------- request decode ----------------
	logic                   accept;
	op_t                    op;
	logic [VALUE_BITS-1:0]  push_value;
	logic [POS_BITS-1:0]    position;
	logic [PW-1:0]          cnt_w;
	logic [PW-1:0]          pos_w;

	logic [CW-1:0]          count_q;   // entries held
	logic [CW-1:0]          count_nxt;
	status_t                st_d;
	logic                   rd_d;
	logic                   we_d;
	logic [AW-1:0]          raddr_d;
	logic [AW-1:0]          waddr_d;
	logic [WORD_BITS-1:0]   wdata_d;
	logic [WORD_BITS-1:0]   rdata;

	logic                   empty_now;
	logic                   full_now;

	assign accept     = s_tvalid && s_tready;
	assign op         = op_t'(s_tuser[1:0]);
	assign push_value = s_tdata[VALUE_BITS-1:0];
	assign position   = s_tdata[VALUE_BITS +: POS_BITS];
	assign cnt_w      = PW'(count_q);
	assign pos_w      = PW'(position);
	assign empty_now  = (count_q == '0);
	assign full_now   = (count_q == CW'(DEPTH));

	// push word is sign-extended (or cut) into the stored word width
	assign wdata_d = WORD_BITS'(signed'(push_value));
	assign waddr_d = AW'(count_q);

	always_comb begin
		st_d      = ST_OK;
		rd_d      = 1'b0;
		we_d      = 1'b0;
		count_nxt = count_q;
		raddr_d   = AW'(count_q - CW'(1));
		case (op)
			OP_PUSH: begin
				if (full_now) begin
					st_d = ST_OVERFLOW;
				end else begin
					we_d      = 1'b1;
					count_nxt = count_q + CW'(1);
				end
			end
			OP_POP: begin
				if (empty_now) begin
					st_d = ST_UNDERFLOW;
				end else begin
					rd_d      = 1'b1;
					count_nxt = count_q - CW'(1);
				end
			end
			OP_PEEK: begin
				if (empty_now) begin
					st_d = ST_UNDERFLOW;
				end else begin
					rd_d = 1'b1;
				end
			end
			OP_PEEP: begin
				if (empty_now) begin
					st_d = ST_UNDERFLOW;
				end else if (pos_w == '0 || pos_w > cnt_w) begin
					st_d = ST_RANGE;
				end else begin
					rd_d    = 1'b1;
					raddr_d = AW'(cnt_w - pos_w);
				end
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	ase_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (accept && we_d),
		.waddr(waddr_d),
		.wdata(wdata_d),
		.re   (accept && rd_d),
		.raddr(raddr_d),
		.rdata(rdata)
	);

	// ---------------- pipeline control ----------------
	logic          valid_s1;
	status_t       status_s1;
	logic          rd_s1;
	logic [CW-1:0] count_s1;

	logic                  out_valid_q;
	status_t               out_status_q;
	logic [VALUE_BITS-1:0] out_value_q;
	logic                  out_empty_q;
	logic                  out_full_q;
	logic [CW-1:0]         out_count_q;

	logic out_load;
	logic s1_free;

	assign out_load = valid_s1 && (!out_valid_q || m_tready);
	assign s1_free  = !valid_s1 || out_load;
	assign s_tready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			if (s1_free) begin
				valid_s1 <= accept;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// stage 1 carries the decode while the RAM read completes
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= st_d;
			rd_s1     <= rd_d;
			count_s1  <= count_nxt;
		end
		if (out_load) begin
			out_status_q <= status_s1;
			out_value_q  <= rd_s1 ? VALUE_BITS'(signed'(rdata)) : '1;
			out_empty_q  <= (count_s1 == '0);
			out_full_q   <= (count_s1 == CW'(DEPTH));
			out_count_q  <= count_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {2'b00, COUNT_BITS'(out_count_q), out_full_q, out_empty_q,
		out_value_q};

	// ---------------- checks ----------------
	`ASE_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "fill count above depth")
	`ASE_ASSERT_IMP(a_ovf_full, out_valid_q && out_status_q == ST_OVERFLOW, out_full_q,
		"overflow reported while not full")
	`ASE_ASSERT_IMP(a_udf_empty, out_valid_q && out_status_q == ST_UNDERFLOW,
		out_empty_q, "underflow reported while not empty")
	`ASE_ASSERT_NXT(a_push_inc, accept && op == OP_PUSH && !full_now,
		count_q == $past(count_q) + CW'(1), "push did not advance the count")

endmodule

// ----- hdl/ase_ram.sv -----
module ase_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
